### rtl/core/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the indexed list store: request and response
// payloads, request types, position modes and status codes.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Fixed field widths of the request and response payloads
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;

  // Request types
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_POP    = 2'd3;

  // Position modes
  localparam logic [1:0] MODE_INDEX = 2'd0;
  localparam logic [1:0] MODE_HEAD  = 2'd1;
  localparam logic [1:0] MODE_TAIL  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOB  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [1:0]               position_mode;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } ils_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         count;
  } ils_rsp_t;

endpackage

### rtl/core/ils_list.sv
// ----------------------------------------------------------------------------
// ils_list
// Entry cells and fill count of the list. Resolves the position of one
// request, shifts all cells in parallel on insert or remove, and forms the
// response in the same cycle.
// ----------------------------------------------------------------------------
module ils_list #(
  parameter int CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            op_valid,
  input  ils_pkg::ils_req_t op_req,
  output ils_pkg::ils_rsp_t op_rsp
);
  import ils_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  logic [DATA_W-1:0] entries_r [CAPACITY];
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;

  logic [XW-1:0] count_x;
  logic [XW-1:0] pos;
  logic          pos_ok;
  logic [1:0]    status;
  logic          do_insert;
  logic          do_remove;
  logic          do_read;
  logic [PW-1:0] pos_idx;

  assign count_x = XW'(count_r);
  assign pos_idx = pos[PW-1:0];

  // Resolve the target position
  always_comb begin
    pos    = '0;
    pos_ok = 1'b1;
    unique case (op_req.position_mode)
      MODE_INDEX: pos = XW'(op_req.index);
      MODE_HEAD:  pos = '0;
      MODE_TAIL: begin
        if (op_req.req_type == REQ_INSERT) begin
          pos = count_x;
        end else if (count_r == '0) begin
          pos_ok = 1'b0;
        end else begin
          pos = count_x - XW'(1);
        end
      end
      default: pos_ok = 1'b0;
    endcase
  end

  // Check bounds and capacity, pick the action
  always_comb begin
    status    = ST_OK;
    do_insert = 1'b0;
    do_remove = 1'b0;
    do_read   = 1'b0;
    if (op_req.req_type == REQ_INSERT) begin
      if (!pos_ok || pos > count_x) begin
        status = ST_OOB;
      end else if (count_r == CW'(CAPACITY)) begin
        status = ST_FULL;
      end else begin
        do_insert = 1'b1;
      end
    end else begin
      if (!pos_ok || pos >= count_x) begin
        status = ST_OOB;
      end else begin
        do_read   = (op_req.req_type != REQ_REMOVE);
        do_remove = (op_req.req_type != REQ_READ);
      end
    end
  end

  // Advance the fill count
  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CW'(1);
    end else if (do_remove) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (op_valid) begin
      count_r <= count_nxt;
    end
  end

  // Shift cells in parallel: up above the position on insert, down on remove
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (op_valid && do_insert) begin
        if (XW'(i) == pos) begin
          entries_r[i] <= op_req.value;
        end else if (XW'(i) > pos) begin
          entries_r[i] <= entries_r[(i > 0) ? i - 1 : 0];
        end
      end else if (op_valid && do_remove && i < CAPACITY - 1) begin
        if (XW'(i) >= pos) begin
          entries_r[i] <= entries_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Form the response
  always_comb begin
    op_rsp.status     = status;
    op_rsp.read_value = do_read ? entries_r[pos_idx] : '0;
    op_rsp.count      = CNT_W'(count_nxt);
  end

endmodule

### rtl/core/indexed_list_store.sv
// Path: a request is held in the input register, applied to the list cells, and
//   its response is held in the response register, which drives out_valid.
// Throughput: one request per cycle while responses are taken; all cells shift in parallel.
// Reset: synchronous, active low; clears the fill count and both valid flags.
//   Entry contents are not cleared and only positions below the count are read.
// ----------------------------------------------------------------------------
// indexed_list_store
// Bounded ordered list of signed 32-bit values with insert, remove, read and
// pop at an index, the head or the tail. Each request yields one response.
// ----------------------------------------------------------------------------
module indexed_list_store #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ils_pkg::ils_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ils_pkg::ils_rsp_t out_data
);
  import ils_pkg::*;

  ils_req_t req_r;
  logic     req_valid_r;
  ils_rsp_t rsp;
  ils_rsp_t rsp_r;
  logic     rsp_valid_r;
  logic     advance;

  // Move the held request on when the response slot is free or being taken
  assign advance   = req_valid_r && (!rsp_valid_r || out_ready);
  assign in_ready  = !req_valid_r || !rsp_valid_r || out_ready;
  assign out_valid = rsp_valid_r;
  assign out_data  = rsp_r;

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_data;
    end
  end

  ils_list #(
    .CAPACITY (CAPACITY)
  ) u_list (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (advance),
    .op_req   (req_r),
    .op_rsp   (rsp)
  );

  // Hold the response until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_valid_r <= 1'b0;
    end else if (advance) begin
      rsp_valid_r <= 1'b1;
    end else if (out_ready) begin
      rsp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_r <= rsp;
    end
  end

endmodule

### rtl/core/ils_checker.sv
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks for the indexed list store, bound to the top level.
// ----------------------------------------------------------------------------
module ils_checker #(
  parameter int CAPACITY = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input ils_pkg::ils_req_t in_data,
  input logic              out_valid,
  input logic              out_ready,
  input ils_pkg::ils_rsp_t out_data
);
  import ils_pkg::*;

  // Hold a stalled request
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("stalled request changed or dropped");

  // Hold a stalled response
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled response changed or dropped");

  // Drop the read value on any failed request
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.read_value == '0)
    else $error("failed request returned a value");

  // Report full only with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.count == CNT_W'(CAPACITY))
    else $error("full status with list below capacity");

  // Clear the response channel on reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid right after reset");

endmodule

bind indexed_list_store ils_checker #(
  .CAPACITY (CAPACITY)
) u_ils_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### sim/testbench.sv
// ----------------------------------------------------------------------------
// indexed_list_store testbench
// Drives insert, remove, read and pop requests through the valid/ready
// request channel and checks every response against an in-bench list model.
// The request and response sides stall at random. A long response hold-off
// backs the pipeline up until the request side stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam int LIST_CAP     = 16;
  localparam int RANDOM_REQS  = 1600;
  localparam int HOLD_CYCLES  = 160;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS   = 2_000_000;

  // Position mode with no meaning; the block must answer out of bounds
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ils_req_t in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ils_rsp_t out_data;

  // Request stream and expected responses
  ils_req_t pending_reqs[$];
  ils_rsp_t expected_rsps[$];

  // List model state
  logic signed [DATA_W-1:0] list_vals[LIST_CAP];
  int list_len  = 0;
  int list_peak = 0;

  // Handshake flags seen at the last rising edge
  logic req_taken = 1'b0;
  logic rsp_taken = 1'b0;

  // Stall control
  int unsigned send_gap    = 0;
  int unsigned accept_wait = 0;
  bit          send_calm   = 1'b0;
  bit          recv_calm   = 1'b0;
  logic        hold_active = 1'b0;

  // Run statistics
  int mismatches    = 0;
  int reqs_accepted = 0;
  int reqs_by_type[4];
  int status_seen[3];

  indexed_list_store #(
    .CAPACITY(LIST_CAP)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  function automatic ils_req_t make_req(logic [1:0] kind, logic [1:0] mode,
                                        logic [IDX_W-1:0] idx,
                                        logic signed [DATA_W-1:0] val);
    ils_req_t r;
    r.req_type      = kind;
    r.position_mode = mode;
    r.index         = idx;
    r.value         = val;
    return r;
  endfunction

  // Wait before the next request or response; flip between calm and busy phases
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // Apply one request to the list model and return the response it yields
  function automatic ils_rsp_t apply_list_request(ils_req_t r);
    ils_rsp_t rsp;
    int       pos;
    bit       pos_ok;
    int       k;
    pos_ok          = 1'b1;
    pos             = 0;
    rsp.status      = ST_OK;
    rsp.read_value  = '0;
    case (r.position_mode)
      MODE_INDEX: pos = int'(r.index);
      MODE_HEAD:  pos = 0;
      MODE_TAIL: begin
        if (r.req_type == REQ_INSERT) pos = list_len;
        else if (list_len == 0) pos_ok = 1'b0;
        else pos = list_len - 1;
      end
      default: pos_ok = 1'b0;
    endcase

    if (r.req_type == REQ_INSERT) begin
      if (!pos_ok || pos > list_len) begin
        rsp.status = ST_OOB;
      end else if (list_len >= LIST_CAP) begin
        rsp.status = ST_FULL;
      end else begin
        // shift later entries up and drop the value into the gap
        for (k = list_len; k > pos; k--) list_vals[k] = list_vals[k-1];
        list_vals[pos] = r.value;
        list_len++;
      end
    end else begin
      if (!pos_ok || pos >= list_len) begin
        rsp.status = ST_OOB;
      end else begin
        if (r.req_type != REQ_REMOVE) rsp.read_value = list_vals[pos];
        if (r.req_type != REQ_READ) begin
          // close the gap left by the removed entry
          for (k = pos; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
          list_len--;
        end
      end
    end
    if (list_len > list_peak) list_peak = list_len;
    rsp.count = list_len[CNT_W-1:0];
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Request driver: hold until accepted, then idle for the drawn gap
  always @(negedge clk) begin : drive_requests
    logic     nv;
    ils_req_t nd;
    nv = in_valid;
    nd = in_data;
    if (rst_n && (!in_valid || req_taken)) begin
      nv = 1'b0;
      if (req_taken) send_gap = hold_active ? 0 : draw_wait(send_calm);
      if (send_gap != 0) begin
        send_gap--;
      end else if (pending_reqs.size() != 0) begin
        nd = pending_reqs.pop_front();
        nv = 1'b1;
      end
    end
    in_valid <= nv;
    in_data  <= nd;
  end

  // Response side ready: random stalls per response, plus the long hold-off
  always @(negedge clk) begin : drive_ready
    if (rsp_taken) accept_wait = draw_wait(recv_calm);
    if (!rst_n || hold_active) begin
      out_ready <= 1'b0;
    end else if (accept_wait != 0) begin
      accept_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check responses, then predict for newly accepted requests
  always @(posedge clk) begin : monitor
    ils_rsp_t want;
    req_taken <= rst_n && in_valid && in_ready;
    rsp_taken <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("response with no request outstanding", out_data.count, '0);
        end else begin
          want = expected_rsps.pop_front();
          if (want.status < 3) status_seen[want.status]++;
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.read_value !== want.read_value)
            report_mismatch("read_value", out_data.read_value, want.read_value);
          if (out_data.count !== want.count)
            report_mismatch("count", out_data.count, want.count);
        end
      end
      if (in_valid && in_ready) begin
        expected_rsps.push_back(apply_list_request(in_data));
        reqs_by_type[in_data.req_type]++;
        reqs_accepted++;
      end
    end
  end

  // Stall the response side long enough to back up the pipeline, twice
  initial begin : hold_off
    wait (reqs_accepted >= 300);
    @(negedge clk) hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_active <= 1'b0;
    wait (reqs_accepted >= 1100);
    @(negedge clk) hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_active <= 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("** indexed_list_store: FAILED **");
    $finish;
  end

  initial begin : run_test
    logic [1:0]               kind;
    logic [1:0]               mode;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] val;
    int                       roll;
    int                       seg_left;
    bit                       fill_bias;

    // Empty list: every access and a bad insert position are out of bounds
    pending_reqs.push_back(make_req(REQ_READ,   MODE_HEAD,   5'd0,  32'sd0));
    pending_reqs.push_back(make_req(REQ_POP,    MODE_TAIL,   5'd0,  32'sd0));
    pending_reqs.push_back(make_req(REQ_REMOVE, MODE_INDEX,  5'd0,  32'sd0));
    pending_reqs.push_back(make_req(REQ_READ,   MODE_TAIL,   5'd31, 32'sd0));
    pending_reqs.push_back(make_req(REQ_INSERT, MODE_INDEX,  5'd1,  32'sd5));
    pending_reqs.push_back(make_req(REQ_INSERT, MODE_UNUSED, 5'd0,  32'sd5));
    // Build a short list with extreme values at head, tail, middle and end
    pending_reqs.push_back(make_req(REQ_INSERT, MODE_HEAD,   5'd9,  32'sh7fffffff));
    pending_reqs.push_back(make_req(REQ_INSERT, MODE_TAIL,   5'd0,  32'sh80000000));
    pending_reqs.push_back(make_req(REQ_INSERT, MODE_INDEX,  5'd1,  -32'sd1));
    pending_reqs.push_back(make_req(REQ_INSERT, MODE_INDEX,  5'd3,  32'sd0));
    pending_reqs.push_back(make_req(REQ_INSERT, MODE_INDEX,  5'd5,  32'sd7));
    pending_reqs.push_back(make_req(REQ_INSERT, MODE_INDEX,  5'd16, 32'sd7));
    // Reads in and just past the bounds, and with the unused mode
    pending_reqs.push_back(make_req(REQ_READ,   MODE_INDEX,  5'd0,  32'sd0));
    pending_reqs.push_back(make_req(REQ_READ,   MODE_TAIL,   5'd0,  32'sd0));
    pending_reqs.push_back(make_req(REQ_READ,   MODE_INDEX,  5'd2,  32'sd0));
    pending_reqs.push_back(make_req(REQ_READ,   MODE_INDEX,  5'd4,  32'sd0));
    pending_reqs.push_back(make_req(REQ_READ,   MODE_UNUSED, 5'd1,  32'sd0));
    // Drain the list through every removal flavor
    pending_reqs.push_back(make_req(REQ_POP,    MODE_INDEX,  5'd1,  32'sd0));
    pending_reqs.push_back(make_req(REQ_REMOVE, MODE_HEAD,   5'd0,  32'sd0));
    pending_reqs.push_back(make_req(REQ_POP,    MODE_TAIL,   5'd0,  32'sd0));
    pending_reqs.push_back(make_req(REQ_REMOVE, MODE_INDEX,  5'd0,  32'sd0));
    pending_reqs.push_back(make_req(REQ_POP,    MODE_HEAD,   5'd0,  32'sd0));

    // Random segments alternate between filling and draining the list
    seg_left  = 0;
    fill_bias = 1'b0;
    repeat (RANDOM_REQS) begin
      if (seg_left == 0) begin
        seg_left  = $urandom_range(16, 48);
        fill_bias = !fill_bias;
      end
      seg_left--;

      roll = $urandom_range(0, 99);
      if (roll < 15) kind = REQ_READ;
      else if (roll < (fill_bias ? 75 : 35)) kind = REQ_INSERT;
      else kind = $urandom_range(0, 1) ? REQ_REMOVE : REQ_POP;

      roll = $urandom_range(0, 99);
      if (roll < 25) mode = MODE_HEAD;
      else if (roll < 50) mode = MODE_TAIL;
      else if (roll < 95) mode = MODE_INDEX;
      else mode = MODE_UNUSED;

      roll = $urandom_range(0, 99);
      if (roll < 5) idx = IDX_W'($urandom_range(17, 31));
      else if (roll < 50) idx = IDX_W'($urandom_range(0, 7));
      else idx = IDX_W'($urandom_range(0, 16));

      case ($urandom_range(0, 15))
        0:       val = 32'sh80000000;
        1:       val = 32'sh7fffffff;
        2:       val = 32'sd0;
        3:       val = -32'sd1;
        default: val = $urandom;
      endcase
      pending_reqs.push_back(make_req(kind, mode, idx, val));
    end

    // Release reset, then let the driver and monitor run
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d insert, %0d remove, %0d read, %0d pop); list peaked at %0d of %0d.",
             reqs_accepted, reqs_by_type[REQ_INSERT], reqs_by_type[REQ_REMOVE],
             reqs_by_type[REQ_READ], reqs_by_type[REQ_POP], list_peak, LIST_CAP);
    $display("Responses: %0d ok, %0d out of bounds, %0d full; %0d mismatches.",
             status_seen[ST_OK], status_seen[ST_OOB], status_seen[ST_FULL], mismatches);
    if (mismatches == 0) begin
      $display("** indexed_list_store: PASSED **");
    end else begin
      $display("** indexed_list_store: FAILED **");
    end
    $finish;
  end

endmodule
